>>> rtl/core/ldlt_pkg.sv
// Shared types, codes and fixed-point helpers for the LDL^T decompose and solve block.
// No dependencies; every other file in rtl/core except ldlt_ram imports this package.
package ldlt_pkg;

   localparam int DATA_W        = 32;
   localparam int ACC_W         = 64;
   localparam int MAX_DIM_DEF   = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int SIZE_W        = 5;
   localparam int BAND_W        = 4;
   localparam int IDX_W         = 4;
   localparam int FUNC_W        = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
   localparam logic [BAND_W-1:0] BAND_RESET = 4'd15;

   localparam logic [FUNC_W-1:0] FN_LOAD_MAT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DECOMP   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_LOAD_RHS = 2'd2;
   localparam logic [FUNC_W-1:0] FN_SOLVE    = 2'd3;

   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_BAND_WIDTH  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_D_PROD,
      S_D_NUM,
      S_D_DIV,
      S_D_RSP,
      S_F_PROD,
      S_F_END,
      S_SCALE,
      S_S_DIV,
      S_B_PROD,
      S_B_END,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      A_HOLD,
      A_LOAD,
      A_NUM,
      A_PROD
   } a_op_type;

   typedef enum logic [1:0] {
      SRC_FS,
      SRC_WV,
      SRC_TV
   } src_type;

   typedef enum logic [1:0] {
      WD_REQ,
      WD_OPA,
      WD_QUO
   } wd_type;

   typedef struct packed {
      logic     fs_we;
      wd_type   fs_wsel;
      logic     tv_we;
      wd_type   tv_wsel;
      logic     wv_we;
      a_op_type a_op;
      src_type  a_src;
      logic     b_ld;
      src_type  b_src;
      logic     mul;
      logic     acc_clr;
      logic     acc_add;
      logic     div_start;
      logic     pivot_clr;
      logic     pivot_track;
      logic     rsp_vec;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[ACC_W-1]}}) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/ldlt_decompose_and_solve.sv
// Top level of the banded LDL^T decompose and solve block.
// Depends on ldlt_pkg, ldlt_ctrl and ldlt_dp.
//
// Usage:
//   Requests enter on req_* and are taken at a clock edge with start high and
//   busy low. func 0 loads a matrix entry, 2 loads an rhs entry; neither gives a
//   response. func 1 factors the stored matrix in place and
//   gives one response (index 0, solution 0, last 1, status = zero pivot seen).
//   func 3 solves with the stored factors and rhs and gives n responses, one
//   per index in ascending order, last on the final one.
//   Responses appear on rsp_* for one cycle each, marked by rsp_valid; the
//   receiver takes every one and cannot stall the block.
//   Cost: decompose does one divide per off-diagonal entry in the band, and
//   solve does one divide per row. The shared multiplier, the one-bit-per-cycle
//   divider and the single read port of the factor store set the run time.
//   csr_* writes matrix_size (index 0) and band_width (index 1) while idle.
//   Reset returns to idle with size 16, band 15 and the pivot flag clear;
//   store contents are undefined until loaded.
module ldlt_decompose_and_solve import ldlt_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [IDX_W-1:0]         req_row,
   input  logic [IDX_W-1:0]         req_col,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_index,
   output logic signed [DATA_W-1:0] rsp_solution,
   output logic                     rsp_last,
   output logic                     rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [SIZE_W-1:0]        csr_data
);

   localparam int AW = $clog2(MAX_DIM);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [AW-1:0] fs_row, fs_col, vec_addr;

   ldlt_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_row   (req_row),
      .req_col   (req_col),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .fs_row    (fs_row),
      .fs_col    (fs_col),
      .vec_addr  (vec_addr),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_index (rsp_index),
      .rsp_last  (rsp_last)
   );

   ldlt_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .fs_row       (fs_row),
      .fs_col       (fs_col),
      .vec_addr     (vec_addr),
      .req_value    (req_value),
      .status       (status),
      .rsp_solution (rsp_solution),
      .rsp_status   (rsp_status)
   );

endmodule

>>> rtl/core/ldlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldlt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/ldlt_div.sv
// Radix-2 restoring divider for signed fixed-point quotients, one bit per cycle.
// Depends on ldlt_pkg.
module ldlt_div import ldlt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DATA_W-1:0] den,
   output logic                     done,
   output logic signed [DATA_W-1:0] quot
);

   localparam int DW = DATA_W + FRAC_BITS;
   localparam int CW = $clog2(DW);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     dvd_ff, dvd_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic              zro_ff, zro_in;
   logic              pos_ff, pos_in;
   logic              nz_ff, nz_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] num_mag;
   logic [DATA_W-1:0] den_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      zro_ff <= zro_in;
      pos_ff <= pos_in;
      nz_ff  <= nz_in;
   end

   always_comb begin
      num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
      den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      trial   = {rem_ff, dvd_ff[DW-1]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      zro_in  = zro_ff;
      pos_in  = pos_ff;
      nz_in   = nz_ff;
      if (start) begin
         dvd_in  = {num_mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dvs_in  = den_mag;
         cnt_in  = '0;
         neg_in  = num[DATA_W-1] ^ den[DATA_W-1];
         zro_in  = (den == '0);
         pos_in  = !num[DATA_W-1];
         nz_in   = (num != '0);
         run_in  = (den != '0);
         done_in = (den == '0);
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DATA_W'(trial - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (zro_ff) begin
         if (!nz_ff) begin
            quot = '0;
         end else if (pos_ff) begin
            quot = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            quot = {1'b1, {(DATA_W-1){1'b0}}};
         end
      end else if (!neg_ff) begin
         if (|dvd_ff[DW-1:DATA_W-1]) begin
            quot = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            quot = dvd_ff[DATA_W-1:0];
         end
      end else begin
         if ((|dvd_ff[DW-1:DATA_W]) || (dvd_ff[DATA_W-1] && (|dvd_ff[DATA_W-2:0]))) begin
            quot = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            quot = DATA_W'(-dvd_ff[DATA_W-1:0]);
         end
      end
   end

   assign done = done_ff;

endmodule

>>> rtl/core/ldlt_dp.sv
// Datapath: factor store, rhs and work vectors, multiplier, accumulator and divider.
// Depends on ldlt_pkg, ldlt_ram and ldlt_div.
module ldlt_dp import ldlt_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int AW = $clog2(MAX_DIM)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [AW-1:0]            fs_row,
   input  logic [AW-1:0]            fs_col,
   input  logic [AW-1:0]            vec_addr,
   input  logic signed [DATA_W-1:0] req_value,
   output dp_status_type            status,
   output logic signed [DATA_W-1:0] rsp_solution,
   output logic                     rsp_status
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic signed [DATA_W-1:0] opa_ff, opa_in;
   logic signed [DATA_W-1:0] opb_ff, opb_in;
   logic signed [DATA_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     pivot_ff, pivot_in;
   logic signed [DATA_W-1:0] fs_rdata, wv_rdata, tv_rdata;
   logic signed [DATA_W-1:0] fs_wdata, tv_wdata;
   logic signed [DATA_W-1:0] a_rd, b_rd, quot;
   logic signed [ACC_W-1:0]  mul_full, mul_rnd, diff;
   logic                     div_done;

   function automatic logic signed [DATA_W-1:0] pick(input src_type s,
         input logic signed [DATA_W-1:0] f, input logic signed [DATA_W-1:0] w,
         input logic signed [DATA_W-1:0] t);
      logic signed [DATA_W-1:0] r;
      case (s)
         SRC_FS:  r = f;
         SRC_WV:  r = w;
         SRC_TV:  r = t;
         default: r = f;
      endcase
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] wsel(input wd_type s,
         input logic signed [DATA_W-1:0] r, input logic signed [DATA_W-1:0] a,
         input logic signed [DATA_W-1:0] q);
      logic signed [DATA_W-1:0] v;
      case (s)
         WD_REQ:  v = r;
         WD_OPA:  v = a;
         WD_QUO:  v = q;
         default: v = r;
      endcase
      return v;
   endfunction

   ldlt_ram #(.WIDTH(DATA_W), .DEPTH(2 ** (2 * AW))) u_fs (
      .clock (clock),
      .we    (cmd.fs_we),
      .waddr ({fs_row, fs_col}),
      .wdata (fs_wdata),
      .raddr ({fs_row, fs_col}),
      .rdata (fs_rdata)
   );

   ldlt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_wv (
      .clock (clock),
      .we    (cmd.wv_we),
      .waddr (vec_addr),
      .wdata (req_value),
      .raddr (vec_addr),
      .rdata (wv_rdata)
   );

   ldlt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_tv (
      .clock (clock),
      .we    (cmd.tv_we),
      .waddr (vec_addr),
      .wdata (tv_wdata),
      .raddr (vec_addr),
      .rdata (tv_rdata)
   );

   ldlt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (opa_ff),
      .den   (fs_rdata),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= 1'b0;
      end else begin
         pivot_ff <= pivot_in;
      end
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      a_rd     = pick(cmd.a_src, fs_rdata, wv_rdata, tv_rdata);
      b_rd     = pick(cmd.b_src, fs_rdata, wv_rdata, tv_rdata);
      fs_wdata = wsel(cmd.fs_wsel, req_value, opa_ff, quot);
      tv_wdata = wsel(cmd.tv_wsel, req_value, opa_ff, quot);
      mul_full = ACC_W'(opa_ff) * ACC_W'(opb_ff);
      mul_rnd  = (mul_full + HALF) >>> FRAC_BITS;
      diff     = ACC_W'(a_rd) - acc_ff;

      opa_in = opa_ff;
      case (cmd.a_op)
         A_HOLD:  opa_in = opa_ff;
         A_LOAD:  opa_in = a_rd;
         A_NUM:   opa_in = sat32(diff);
         A_PROD:  opa_in = prod_ff;
         default: opa_in = opa_ff;
      endcase
      opb_in  = cmd.b_ld ? b_rd : opb_ff;
      prod_in = cmd.mul ? sat32(mul_rnd) : prod_ff;

      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      pivot_in = pivot_ff;
      if (cmd.pivot_clr) begin
         pivot_in = 1'b0;
      end else if (cmd.div_start && cmd.pivot_track && (fs_rdata == '0)) begin
         pivot_in = 1'b1;
      end
   end

   assign status.div_done = div_done;
   assign rsp_solution    = cmd.rsp_vec ? tv_rdata : '0;
   assign rsp_status      = pivot_ff;

endmodule

>>> rtl/core/ldlt_ctrl.sv
// Controller: configuration registers, command decode and the loop sequencer.
// Depends on ldlt_pkg; drives ldlt_dp through dp_cmd_type.
module ldlt_ctrl import ldlt_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int AW = $clog2(MAX_DIM),
   localparam int IW = $clog2(MAX_DIM + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data,
   output dp_cmd_type        cmd,
   output logic [AW-1:0]     fs_row,
   output logic [AW-1:0]     fs_col,
   output logic [AW-1:0]     vec_addr,
   input  dp_status_type     status,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_index,
   output logic              rsp_last
);

   state_type         state_ff, state_in;
   logic [2:0]        ph_ff, ph_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [IW-1:0]     l_ff, l_in;
   logic [SIZE_W-1:0] size_ff;
   logic [BAND_W-1:0] bw_ff;
   logic [IW-1:0]     dim, i_inc, bs_i, bs_i1;
   logic              last_i;

   function automatic logic [IW-1:0] bstart(input logic [IW-1:0] x,
         input logic [BAND_W-1:0] b);
      logic [IW-1:0] r;
      if (32'(x) > 32'(b)) begin
         r = IW'(32'(x) - 32'(b));
      end else begin
         r = '0;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= '0;
         size_ff  <= SIZE_RESET;
         bw_ff    <= BAND_RESET;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATRIX_SIZE: size_ff <= csr_data;
               CSR_BAND_WIDTH:  bw_ff   <= csr_data[BAND_W-1:0];
               default:         size_ff <= size_ff;
            endcase
         end
      end
      i_ff <= i_in;
      j_ff <= j_in;
      l_ff <= l_in;
   end

   always_comb begin
      if (size_ff == '0) begin
         dim = IW'(1);
      end else if (32'(size_ff) > 32'(MAX_DIM)) begin
         dim = IW'(MAX_DIM);
      end else begin
         dim = IW'(size_ff);
      end
      i_inc  = i_ff + IW'(1);
      last_i = (i_inc == dim);
      bs_i   = bstart(i_ff, bw_ff);
      bs_i1  = bstart(i_inc, bw_ff);
   end

   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      l_in      = l_ff;
      cmd       = '0;
      fs_row    = AW'(i_ff);
      fs_col    = AW'(j_ff);
      vec_addr  = AW'(i_ff);
      rsp_valid = 1'b0;
      rsp_index = '0;
      rsp_last  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            ph_in = '0;
            if (start) begin
               case (req_func)
                  FN_LOAD_MAT: begin
                     if (32'(req_row) < 32'(MAX_DIM) && 32'(req_col) < 32'(MAX_DIM)) begin
                        cmd.fs_we   = 1'b1;
                        cmd.fs_wsel = WD_REQ;
                        if (req_col > req_row) begin
                           fs_row = AW'(req_col);
                           fs_col = AW'(req_row);
                        end else begin
                           fs_row = AW'(req_row);
                           fs_col = AW'(req_col);
                        end
                     end
                  end
                  FN_LOAD_RHS: begin
                     if (32'(req_row) < 32'(MAX_DIM)) begin
                        cmd.wv_we = 1'b1;
                        vec_addr  = AW'(req_row);
                     end
                  end
                  FN_DECOMP: begin
                     i_in          = '0;
                     j_in          = '0;
                     l_in          = '0;
                     cmd.acc_clr   = 1'b1;
                     cmd.pivot_clr = 1'b1;
                     state_in      = S_D_PROD;
                  end
                  FN_SOLVE: begin
                     i_in        = '0;
                     j_in        = '0;
                     cmd.acc_clr = 1'b1;
                     state_in    = S_F_PROD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_D_PROD: begin
            case (ph_ff)
               3'd0: begin
                  if (l_ff >= j_ff) begin
                     state_in = S_D_NUM;
                  end else begin
                     fs_row = AW'(i_ff);
                     fs_col = AW'(l_ff);
                     ph_in  = 3'd1;
                  end
               end
               3'd1: begin
                  fs_row    = AW'(j_ff);
                  fs_col    = AW'(l_ff);
                  cmd.a_op  = A_LOAD;
                  cmd.a_src = SRC_FS;
                  ph_in     = 3'd2;
               end
               3'd2: begin
                  fs_row    = AW'(l_ff);
                  fs_col    = AW'(l_ff);
                  cmd.b_ld  = 1'b1;
                  cmd.b_src = SRC_FS;
                  ph_in     = 3'd3;
               end
               3'd3: begin
                  fs_row    = AW'(l_ff);
                  fs_col    = AW'(l_ff);
                  cmd.mul   = 1'b1;
                  cmd.b_ld  = 1'b1;
                  cmd.b_src = SRC_FS;
                  ph_in     = 3'd4;
               end
               3'd4: begin
                  cmd.a_op = A_PROD;
                  ph_in    = 3'd5;
               end
               3'd5: begin
                  cmd.mul = 1'b1;
                  ph_in   = 3'd6;
               end
               default: begin
                  cmd.acc_add = 1'b1;
                  l_in        = l_ff + IW'(1);
                  ph_in       = 3'd0;
               end
            endcase
         end

         S_D_NUM: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  cmd.a_op  = A_NUM;
                  cmd.a_src = SRC_FS;
                  fs_row    = AW'(j_ff);
                  fs_col    = AW'(j_ff);
                  ph_in     = 3'd2;
               end
               default: begin
                  ph_in = 3'd0;
                  if (j_ff == i_ff) begin
                     cmd.fs_we   = 1'b1;
                     cmd.fs_wsel = WD_OPA;
                     if (last_i) begin
                        state_in = S_D_RSP;
                     end else begin
                        i_in        = i_inc;
                        j_in        = bs_i1;
                        l_in        = bs_i1;
                        cmd.acc_clr = 1'b1;
                        state_in    = S_D_PROD;
                     end
                  end else begin
                     cmd.div_start   = 1'b1;
                     cmd.pivot_track = 1'b1;
                     state_in        = S_D_DIV;
                  end
               end
            endcase
         end

         S_D_DIV: begin
            if (status.div_done) begin
               cmd.fs_we   = 1'b1;
               cmd.fs_wsel = WD_QUO;
               cmd.acc_clr = 1'b1;
               j_in        = j_ff + IW'(1);
               l_in        = bs_i;
               state_in    = S_D_PROD;
            end
         end

         S_D_RSP: begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            state_in  = S_IDLE;
         end

         S_F_PROD: begin
            fs_row   = AW'(i_ff);
            fs_col   = AW'(j_ff);
            vec_addr = AW'(j_ff);
            case (ph_ff)
               3'd0: begin
                  if (j_ff >= i_ff) begin
                     state_in = S_F_END;
                  end else begin
                     ph_in = 3'd1;
                  end
               end
               3'd1: begin
                  cmd.a_op  = A_LOAD;
                  cmd.a_src = SRC_TV;
                  cmd.b_ld  = 1'b1;
                  cmd.b_src = SRC_FS;
                  ph_in     = 3'd2;
               end
               3'd2: begin
                  cmd.mul = 1'b1;
                  ph_in   = 3'd3;
               end
               default: begin
                  cmd.acc_add = 1'b1;
                  j_in        = j_ff + IW'(1);
                  ph_in       = 3'd0;
               end
            endcase
         end

         S_F_END: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  cmd.a_op  = A_NUM;
                  cmd.a_src = SRC_WV;
                  ph_in     = 3'd2;
               end
               default: begin
                  cmd.tv_we   = 1'b1;
                  cmd.tv_wsel = WD_OPA;
                  ph_in       = 3'd0;
                  if (last_i) begin
                     i_in     = '0;
                     state_in = S_SCALE;
                  end else begin
                     i_in        = i_inc;
                     j_in        = bs_i1;
                     cmd.acc_clr = 1'b1;
                     state_in    = S_F_PROD;
                  end
               end
            endcase
         end

         S_SCALE: begin
            fs_col = AW'(i_ff);
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  cmd.a_op  = A_LOAD;
                  cmd.a_src = SRC_TV;
                  ph_in     = 3'd2;
               end
               default: begin
                  cmd.div_start = 1'b1;
                  ph_in         = 3'd0;
                  state_in      = S_S_DIV;
               end
            endcase
         end

         S_S_DIV: begin
            fs_col = AW'(i_ff);
            if (status.div_done) begin
               cmd.tv_we   = 1'b1;
               cmd.tv_wsel = WD_QUO;
               if (last_i) begin
                  i_in        = IW'(dim - IW'(1));
                  j_in        = dim;
                  cmd.acc_clr = 1'b1;
                  state_in    = S_B_PROD;
               end else begin
                  i_in     = i_inc;
                  state_in = S_SCALE;
               end
            end
         end

         S_B_PROD: begin
            fs_row   = AW'(j_ff);
            fs_col   = AW'(i_ff);
            vec_addr = AW'(j_ff);
            case (ph_ff)
               3'd0: begin
                  if (j_ff < dim && 32'(j_ff) <= 32'(i_ff) + 32'(bw_ff)) begin
                     ph_in = 3'd1;
                  end else begin
                     state_in = S_B_END;
                  end
               end
               3'd1: begin
                  cmd.a_op  = A_LOAD;
                  cmd.a_src = SRC_FS;
                  cmd.b_ld  = 1'b1;
                  cmd.b_src = SRC_TV;
                  ph_in     = 3'd2;
               end
               3'd2: begin
                  cmd.mul = 1'b1;
                  ph_in   = 3'd3;
               end
               default: begin
                  cmd.acc_add = 1'b1;
                  j_in        = j_ff + IW'(1);
                  ph_in       = 3'd0;
               end
            endcase
         end

         S_B_END: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  cmd.a_op  = A_NUM;
                  cmd.a_src = SRC_TV;
                  ph_in     = 3'd2;
               end
               default: begin
                  cmd.tv_we   = 1'b1;
                  cmd.tv_wsel = WD_OPA;
                  ph_in       = 3'd0;
                  if (i_ff == '0) begin
                     state_in = S_OUT;
                  end else begin
                     i_in        = i_ff - IW'(1);
                     j_in        = i_ff;
                     cmd.acc_clr = 1'b1;
                     state_in    = S_B_PROD;
                  end
               end
            endcase
         end

         S_OUT: begin
            if (ph_ff == 3'd0) begin
               ph_in = 3'd1;
            end else begin
               rsp_valid   = 1'b1;
               cmd.rsp_vec = 1'b1;
               rsp_index   = IDX_W'(i_ff);
               rsp_last    = last_i;
               ph_in       = 3'd0;
               if (last_i) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_inc;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response strobe while idle");
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_D_DIV || state_ff == S_S_DIV))
      else $error("divider finished outside a divide wait");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && state_ff == S_D_RSP) |-> rsp_last)
      else $error("decompose response without last");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("still busy after final response");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start) |=> !cmd.div_start)
      else $error("divider restarted back to back");
`endif

endmodule
